// ===== rtl/core/wsd_pkg.sv =====
package wsd_pkg;

  typedef struct packed {
    logic       mode;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] payload_byte;
    logic       message_end;
  } out_t;

  // Result kinds
  localparam logic [1:0] KIND_BYTE      = 2'd0;
  localparam logic [1:0] KIND_EMPTY_END = 2'd1;
  localparam logic [1:0] KIND_CLOSE     = 2'd2;
  localparam logic [1:0] KIND_HANDSHAKE = 2'd3;

  // Input modes
  localparam logic MODE_BYTE    = 1'b0;
  localparam logic MODE_RESTART = 1'b1;

  // Frame parser phases
  localparam logic [2:0] PH_FIRST   = 3'd0;
  localparam logic [2:0] PH_SECOND  = 3'd1;
  localparam logic [2:0] PH_EXTLEN  = 3'd2;
  localparam logic [2:0] PH_MASK    = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;

  // Opcodes
  localparam logic [3:0] OP_CONT  = 4'h0;
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_BIN   = 4'h2;
  localparam logic [3:0] OP_CLOSE = 4'h8;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;

endpackage

// ===== rtl/core/wsd_parser.sv =====
module wsd_parser
  import wsd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic step_en,
  input  in_t  item,
  output logic res_valid,
  output out_t res
);

  logic        hs_done_r,  hs_done_nxt;
  logic [1:0]  crlf_r,     crlf_nxt;
  logic        closed_r,   closed_nxt;
  logic [2:0]  phase_r,    phase_nxt;
  logic [3:0]  len_left_r, len_left_nxt;
  logic [3:0]  opcode_r,   opcode_nxt;
  logic        fin_r,      fin_nxt;
  logic        masked_r,   masked_nxt;
  logic [63:0] remain_r,   remain_nxt;
  logic [31:0] key_r,      key_nxt;
  logic [1:0]  mpos_r,     mpos_nxt;
  logic        open_r,     open_nxt;

  logic [7:0]  b;
  logic        after_len;
  logic        hdr_fin;
  logic        last;
  logic        deliver;
  logic [7:0]  key_byte;

  assign b = item.rx_byte;

  always_comb begin
    case (mpos_r)
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  always_comb begin
    hs_done_nxt  = hs_done_r;
    crlf_nxt     = crlf_r;
    closed_nxt   = closed_r;
    phase_nxt    = phase_r;
    len_left_nxt = len_left_r;
    opcode_nxt   = opcode_r;
    fin_nxt      = fin_r;
    masked_nxt   = masked_r;
    remain_nxt   = remain_r;
    key_nxt      = key_r;
    mpos_nxt     = mpos_r;
    open_nxt     = open_r;
    res_valid    = 1'b0;
    res          = '0;
    after_len    = 1'b0;
    hdr_fin      = 1'b0;
    last         = 1'b0;
    deliver      = 1'b0;

    if (item.mode == MODE_RESTART) begin
      hs_done_nxt  = 1'b0;
      crlf_nxt     = '0;
      closed_nxt   = 1'b0;
      phase_nxt    = PH_FIRST;
      len_left_nxt = '0;
      opcode_nxt   = '0;
      fin_nxt      = 1'b0;
      masked_nxt   = 1'b0;
      remain_nxt   = '0;
      key_nxt      = '0;
      mpos_nxt     = '0;
      open_nxt     = 1'b0;
    end else if (!hs_done_r) begin
      // Scan the upgrade response for the blank line that ends it.
      if (b == CHAR_CR) begin
        crlf_nxt = (crlf_r == 2'd0 || crlf_r == 2'd2) ? crlf_r + 2'd1 : 2'd1;
      end else if (b == CHAR_LF && crlf_r == 2'd1) begin
        crlf_nxt = 2'd2;
      end else if (b == CHAR_LF && crlf_r == 2'd3) begin
        crlf_nxt    = 2'd0;
        hs_done_nxt = 1'b1;
        res_valid   = 1'b1;
        res.kind    = KIND_HANDSHAKE;
      end else begin
        crlf_nxt = 2'd0;
      end
    end else if (!closed_r) begin
      case (phase_r)
        PH_SECOND: begin
          masked_nxt = b[7];
          key_nxt    = '0;
          mpos_nxt   = '0;
          if (b[6:0] == LEN_EXT16 || b[6:0] == LEN_EXT64) begin
            len_left_nxt = (b[6:0] == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
            remain_nxt   = '0;
            phase_nxt    = PH_EXTLEN;
          end else begin
            remain_nxt = {57'd0, b[6:0]};
            after_len  = 1'b1;
          end
        end
        PH_EXTLEN: begin
          remain_nxt   = {remain_r[55:0], b};
          len_left_nxt = len_left_r - 4'd1;
          after_len    = (len_left_nxt == 4'd0);
        end
        PH_MASK: begin
          key_nxt  = {key_r[23:0], b};
          mpos_nxt = mpos_r + 2'd1;
          hdr_fin  = (mpos_nxt == 2'd0);
        end
        PH_PAYLOAD: begin
          mpos_nxt   = mpos_r + 2'd1;
          remain_nxt = remain_r - 64'd1;
          last       = (remain_nxt == 64'd0);
          if (open_r && (opcode_r == OP_CONT || opcode_r == OP_TEXT)) begin
            res_valid        = 1'b1;
            res.kind         = KIND_BYTE;
            res.payload_byte = masked_r ? (b ^ key_byte) : b;
            res.message_end  = last && fin_r;
            if (last && fin_r) begin
              open_nxt = 1'b0;
            end
          end
          if (last) begin
            phase_nxt = PH_FIRST;
            if (opcode_r == OP_CLOSE) begin
              closed_nxt = 1'b1;
              res_valid  = 1'b1;
              res        = '0;
              res.kind   = KIND_CLOSE;
            end
          end
        end
        default: begin
          fin_nxt    = b[7];
          opcode_nxt = b[3:0];
          phase_nxt  = PH_SECOND;
        end
      endcase

      if (after_len) begin
        if (masked_nxt) begin
          phase_nxt = PH_MASK;
          mpos_nxt  = '0;
        end else begin
          hdr_fin = 1'b1;
        end
      end

      // End of header: open or drop the message, and finish empty frames here.
      if (hdr_fin) begin
        phase_nxt = PH_PAYLOAD;
        mpos_nxt  = '0;
        if (opcode_r == OP_TEXT) begin
          open_nxt = 1'b1;
        end else if (opcode_r == OP_BIN) begin
          open_nxt = 1'b0;
        end
        deliver = open_nxt && (opcode_r == OP_CONT || opcode_r == OP_TEXT);
        if (remain_nxt == 64'd0) begin
          phase_nxt = PH_FIRST;
          if (opcode_r == OP_CLOSE) begin
            closed_nxt = 1'b1;
            res_valid  = 1'b1;
            res.kind   = KIND_CLOSE;
          end else if (deliver && fin_r) begin
            open_nxt        = 1'b0;
            res_valid       = 1'b1;
            res.kind        = KIND_EMPTY_END;
            res.message_end = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hs_done_r  <= 1'b0;
      crlf_r     <= '0;
      closed_r   <= 1'b0;
      phase_r    <= PH_FIRST;
      len_left_r <= '0;
      opcode_r   <= '0;
      fin_r      <= 1'b0;
      masked_r   <= 1'b0;
      remain_r   <= '0;
      key_r      <= '0;
      mpos_r     <= '0;
      open_r     <= 1'b0;
    end else if (step_en) begin
      hs_done_r  <= hs_done_nxt;
      crlf_r     <= crlf_nxt;
      closed_r   <= closed_nxt;
      phase_r    <= phase_nxt;
      len_left_r <= len_left_nxt;
      opcode_r   <= opcode_nxt;
      fin_r      <= fin_nxt;
      masked_r   <= masked_nxt;
      remain_r   <= remain_nxt;
      key_r      <= key_nxt;
      mpos_r     <= mpos_nxt;
      open_r     <= open_nxt;
    end
  end

endmodule

// ===== rtl/core/websocket_client_deframer.sv =====
// Receive-side WebSocket client deframer, one link byte per input word.
// Input channel (in_valid/in_ready/in_data): each word is either a received
// byte (mode 0) or a new-connection marker (mode 1) that restarts the
// handshake scan and the frame parser without producing output.
// Output channel (out_valid/out_ready/out_data): at most one word per input
// word: an unmasked text payload byte, an empty message end, a close report
// or a handshake-complete report. Header bytes and dropped frames give none.
// A word passes through the input register and then the output register.
// Throughput is one word per cycle while the receiver does not stall;
// the parser state and the per-byte decode sit between those two registers.
// A synchronous active-low reset clears both valid flags and all parser state,
// so the block starts by scanning for the end of the upgrade response.
// When the receiver stalls, the output register holds its word, the input
// register holds the next one, and in_ready drops only when both are full.
module websocket_client_deframer
  import wsd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic in_v_r;
  in_t  in_d_r;
  logic out_v_r;
  out_t out_d_r;

  logic step_en;
  logic res_valid;
  out_t res;

  // The buffered word is processed whenever the output register is free or its word is taken.
  assign step_en  = in_v_r && (!out_v_r || out_ready);
  assign in_ready = !in_v_r || step_en;

  wsd_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_en  (step_en),
    .item     (in_d_r),
    .res_valid(res_valid),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_v_r <= in_valid;
      end
      if (step_en) begin
        out_v_r <= res_valid;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_d_r <= in_data;
    end
    if (step_en && res_valid) begin
      out_d_r <= res;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

endmodule
